// File: src/i2cmbs_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
`timescale 1ns / 1ps

package i2cmbs_pkg;

	// Item kinds; K_TICK doubles as the idle command code.
	typedef enum logic [2:0] {
		K_TICK  = 3'd0,
		K_START = 3'd1,
		K_STOP  = 3'd2,
		K_WRITE = 3'd3,
		K_READ  = 3'd4,
		K_WACK  = 3'd5,
		K_ACK   = 3'd6,
		K_NACK  = 3'd7
	} kind_t;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned BIT_CNT_W     = 4;
	localparam int unsigned PHASE_W       = 4;

	localparam logic [7:0] SS_UNITS_RST    = 8'd4;
	localparam logic [7:0] BIT_UNITS_RST   = 8'd2;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	localparam logic [1:0] CFG_SS_UNITS    = 2'd0;
	localparam logic [1:0] CFG_BIT_UNITS   = 2'd1;
	localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;

endpackage

// File: src/i2c_master_bit_sequencer.sv
// A request is captured in the input register, and its result is then registered in the output
// register together with the new sequencer state.
// Throughput: one request per cycle unless the output stalls; the state update is a single pass
// of logic from the input register into the sequencer state and the output register.
// Reset: arst_n clears all control state at once; the sequencer state releases the bus with SCL
// high, the timing registers take their default values, and the output data register is not reset.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer
	import i2cmbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] kind,
	input  logic [7:0] write_data,
	input  logic       sda_in,

	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl,
	output logic       sda_drive,
	output logic       sda_level,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       ack_error,
	output logic       rejected,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	// Timing registers
	logic [7:0] ss_units_q, bit_units_q, ack_timeout_q;

	// Input register
	logic        valid_s1;
	kind_t       kind_s1;
	logic [7:0]  data_s1;
	logic        sda_s1;

	// Sequencer state
	kind_t                cmd_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [7:0]           delay_q, shift_q, poll_q, last_read_q;
	logic                 scl_q, sda_oe_q, sda_out_q, err_q;

	// Next-state values
	kind_t                cmd_n;
	logic [PHASE_W-1:0]   phase_n;
	logic [BIT_CNT_W-1:0] bit_cnt_n, bit_inc;
	logic [7:0]           delay_n, shift_n, poll_n, last_read_n, units, delay_inc;
	logic                 scl_n, sda_oe_n, sda_out_n, err_n, done_n, rej_n;

	logic advance;

	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_units_q    <= SS_UNITS_RST;
			bit_units_q   <= BIT_UNITS_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SS_UNITS:    ss_units_q    <= cfg_data;
				CFG_BIT_UNITS:   bit_units_q   <= cfg_data;
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind_t'(kind);
			data_s1 <= write_data;
			sda_s1  <= sda_in;
		end
	end

	always_comb begin
		cmd_n       = cmd_q;
		phase_n     = phase_q;
		bit_cnt_n   = bit_cnt_q;
		delay_n     = delay_q;
		shift_n     = shift_q;
		poll_n      = poll_q;
		last_read_n = last_read_q;
		scl_n       = scl_q;
		sda_oe_n    = sda_oe_q;
		sda_out_n   = sda_out_q;
		err_n       = err_q;
		done_n      = 1'b0;
		rej_n       = 1'b0;

		units = (cmd_q == K_START || cmd_q == K_STOP) ? ss_units_q : bit_units_q;
		if (units == 8'd0) begin
			units = 8'd1;
		end
		delay_inc = delay_q + 8'd1;
		bit_inc   = bit_cnt_q + {{(BIT_CNT_W-1){1'b0}}, 1'b1};

		if (kind_s1 != K_TICK) begin
			if (cmd_q != K_TICK) begin
				rej_n = 1'b1;
			end else begin
				cmd_n     = kind_s1;
				phase_n   = '0;
				delay_n   = '0;
				bit_cnt_n = '0;
				poll_n    = '0;
				err_n     = 1'b0;
				unique case (kind_s1)
					K_TICK: ;
					K_START: begin
						scl_n = 1'b1; sda_oe_n = 1'b1; sda_out_n = 1'b1;
					end
					K_STOP: begin
						scl_n = 1'b0; sda_oe_n = 1'b1; sda_out_n = 1'b0;
					end
					K_WRITE: begin
						scl_n     = 1'b0;
						sda_oe_n  = 1'b1;
						sda_out_n = data_s1[7];
						shift_n   = {data_s1[6:0], 1'b0};
					end
					K_READ: begin
						scl_n = 1'b0; sda_oe_n = 1'b0; shift_n = '0;
					end
					K_WACK: begin
						sda_oe_n = 1'b0; sda_out_n = 1'b1;
					end
					K_ACK: begin
						scl_n = 1'b0; sda_oe_n = 1'b1; sda_out_n = 1'b0;
					end
					K_NACK: begin
						scl_n = 1'b0; sda_oe_n = 1'b1; sda_out_n = 1'b1;
					end
				endcase
			end
		end else if (cmd_q != K_TICK) begin
			if (cmd_q == K_WACK && phase_q == PHASE_W'(2)) begin
				// Polling for the acknowledge, one sample per tick.
				if (!sda_s1) begin
					scl_n   = 1'b0;
					cmd_n   = K_TICK;
					phase_n = '0;
					delay_n = '0;
					done_n  = 1'b1;
				end else if (poll_q >= ack_timeout_q) begin
					err_n     = 1'b1;
					cmd_n     = K_STOP;
					phase_n   = '0;
					delay_n   = '0;
					sda_oe_n  = 1'b1;
					scl_n     = 1'b0;
					sda_out_n = 1'b0;
				end else begin
					poll_n = poll_q + 8'd1;
				end
			end else if (delay_inc < units) begin
				delay_n = delay_inc;
			end else begin
				delay_n = '0;
				unique case (cmd_q)
					K_TICK: ;
					K_START, K_STOP: begin
						if (phase_q == PHASE_W'(0)) begin
							if (cmd_q == K_START) sda_out_n = 1'b0;
							else scl_n = 1'b1;
							phase_n = phase_q + PHASE_W'(1);
						end else if (phase_q == PHASE_W'(1)) begin
							if (cmd_q == K_START) scl_n = 1'b0;
							else sda_out_n = 1'b1;
							phase_n = phase_q + PHASE_W'(1);
						end else begin
							cmd_n   = K_TICK;
							phase_n = '0;
							done_n  = 1'b1;
						end
					end
					K_WRITE: begin
						if (phase_q == PHASE_W'(0)) begin
							scl_n   = 1'b1;
							phase_n = PHASE_W'(1);
						end else if (phase_q == PHASE_W'(1)) begin
							scl_n   = 1'b0;
							phase_n = PHASE_W'(2);
						end else begin
							bit_cnt_n = bit_inc;
							if (bit_inc >= BIT_CNT_W'(BITS_PER_BYTE)) begin
								cmd_n   = K_TICK;
								phase_n = '0;
								done_n  = 1'b1;
							end else begin
								sda_out_n = shift_q[7];
								shift_n   = {shift_q[6:0], 1'b0};
								phase_n   = '0;
							end
						end
					end
					K_READ: begin
						if (phase_q == PHASE_W'(0)) begin
							scl_n   = 1'b1;
							shift_n = {shift_q[6:0], sda_s1};
							phase_n = PHASE_W'(1);
						end else begin
							bit_cnt_n = bit_inc;
							if (bit_inc >= BIT_CNT_W'(BITS_PER_BYTE)) begin
								// SCL stays high after the last bit.
								last_read_n = shift_q;
								cmd_n       = K_TICK;
								phase_n     = '0;
								done_n      = 1'b1;
							end else begin
								scl_n   = 1'b0;
								phase_n = '0;
							end
						end
					end
					K_WACK: begin
						if (phase_q == PHASE_W'(0)) scl_n = 1'b1;
						phase_n = phase_q + PHASE_W'(1);
					end
					K_ACK, K_NACK: begin
						if (phase_q == PHASE_W'(0)) begin
							scl_n   = 1'b1;
							phase_n = PHASE_W'(1);
						end else begin
							scl_n   = 1'b0;
							cmd_n   = K_TICK;
							phase_n = '0;
							done_n  = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= K_TICK;
			phase_q     <= '0;
			bit_cnt_q   <= '0;
			delay_q     <= '0;
			shift_q     <= '0;
			poll_q      <= '0;
			last_read_q <= '0;
			scl_q       <= 1'b1;
			sda_oe_q    <= 1'b0;
			sda_out_q   <= 1'b1;
			err_q       <= 1'b0;
		end else if (advance) begin
			cmd_q       <= cmd_n;
			phase_q     <= phase_n;
			bit_cnt_q   <= bit_cnt_n;
			delay_q     <= delay_n;
			shift_q     <= shift_n;
			poll_q      <= poll_n;
			last_read_q <= last_read_n;
			scl_q       <= scl_n;
			sda_oe_q    <= sda_oe_n;
			sda_out_q   <= sda_out_n;
			err_q       <= err_n;
		end
	end

	// Output register
	logic       valid_s2;
	logic       scl_s2, sda_oe_s2, sda_out_s2, busy_s2, done_s2, err_s2, rej_s2;
	logic [7:0] read_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			scl_s2     <= scl_n;
			sda_oe_s2  <= sda_oe_n;
			sda_out_s2 <= sda_out_n;
			busy_s2    <= (cmd_n != K_TICK);
			done_s2    <= done_n;
			read_s2    <= last_read_n;
			err_s2     <= err_n;
			rej_s2     <= rej_n;
		end
	end

	assign out_valid = valid_s2;
	assign scl       = scl_s2;
	assign sda_drive = sda_oe_s2;
	assign sda_level = sda_out_s2;
	assign busy_res  = busy_s2;
	assign done_res  = done_s2;
	assign read_data = read_s2;
	assign ack_error = err_s2;
	assign rejected  = rej_s2;

`ifndef SYNTH
	// A rejected command leaves the running sequence in place.
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rej_s2) |-> busy_s2)
		else $error("rejected request reported while idle");

	// Completion always returns the sequencer to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2) |-> !busy_s2)
		else $error("done reported with sequence still busy");

	// During a read the master never drives SDA.
	a_read_released: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q == K_READ) |-> !sda_oe_q)
		else $error("SDA driven during read");
`endif

endmodule
